// ===== design/pwf_pkg.sv =====
// Shared types and constants for the primer window filter.
// Used by pwf_window, pwf_check and primer_window_filter_top; no dependencies.
package pwf_pkg;

   localparam int WINDOW_LEN = 20;
   localparam int POS_BITS   = 16;
   localparam int WIN_W      = 2 * WINDOW_LEN;
   localparam int LEN_W      = 16;
   localparam int GC_W       = 5;
   localparam int TM_W       = 14;
   localparam int TM_OUT_W   = 13;
   localparam int RUN_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;
   localparam int TM_BASE    = 3128;
   localparam int TM_STEP    = 205;

   localparam int REQ_TDATA_W = ((2 + LEN_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((POS_BITS + WIN_W + GC_W + TM_OUT_W + 7) / 8) * 8;

   localparam logic [GC_W-1:0]  MIN_GC_RST    = GC_W'(9);
   localparam logic [GC_W-1:0]  MAX_GC_RST    = GC_W'(11);
   localparam logic [TM_W-1:0]  MIN_TM_RST    = TM_W'(5240);
   localparam logic [TM_W-1:0]  MAX_TM_RST    = TM_W'(5540);
   localparam logic [RUN_W-1:0] RUN_LIMIT_RST = RUN_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_GC    = 3'd0,
      CSR_MAX_GC    = 3'd1,
      CSR_MIN_TM    = 3'd2,
      CSR_MAX_TM    = 3'd3,
      CSR_RUN_LIMIT = 3'd4,
      CSR_REJ_START = 3'd5,
      CSR_REJ_ENDS  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GC_W-1:0]  min_gc;
      logic [GC_W-1:0]  max_gc;
      logic [TM_W-1:0]  min_tm;
      logic [TM_W-1:0]  max_tm;
      logic [RUN_W-1:0] run_limit;
      logic             rej_start;
      logic             rej_ends;
   } cfg_type;

   typedef struct packed {
      logic [POS_BITS-1:0] offset;
      logic [WIN_W-1:0]    bases;
   } cand_type;

   typedef struct packed {
      logic [TM_OUT_W-1:0] tm;
      logic [GC_W-1:0]     gc;
      logic [WIN_W-1:0]    bases;
      logic [POS_BITS-1:0] offset;
   } rsp_type;

   function automatic logic is_gc(input logic [1:0] b);
      return b[0] ^ b[1];
   endfunction

endpackage

// ===== design/pwf_window.sv =====
// Segment tracking and sliding base window; registers each full window of a segment whose stated length is at least
// 2*WINDOW_LEN bases as a candidate. Depends on pwf_pkg.
module pwf_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [1:0]                    base,
   input  logic                          segment_first,
   input  logic [pwf_pkg::LEN_W-1:0]     segment_length,
   output logic                          cand_valid,
   input  logic                          cand_ready,
   output pwf_pkg::cand_type             cand
);

   logic [pwf_pkg::POS_BITS-1:0] seen_ff, seen_in, seen_base, seen_next;
   logic [pwf_pkg::WIN_W-1:0]    win_ff, win_in, win_base, win_shift;
   logic                         lenok_ff, lenok_in;
   logic                         valid_ff;
   pwf_pkg::cand_type            cand_ff, cand_in;
   logic                         sat, hit, accept;

   assign accept   = in_valid && in_ready;
   assign in_ready = !valid_ff || cand_ready;

   always_comb begin
      seen_base = segment_first ? '0 : seen_ff;
      win_base  = segment_first ? '0 : win_ff;
      lenok_in  = segment_first ?
                  (segment_length >= pwf_pkg::LEN_W'(2 * pwf_pkg::WINDOW_LEN)) : lenok_ff;
      sat       = &seen_base;
      seen_next = seen_base + pwf_pkg::POS_BITS'(1);
      win_shift = {win_base[pwf_pkg::WIN_W-3:0], base};
      seen_in   = sat ? seen_base : seen_next;
      win_in    = sat ? win_base : win_shift;
      hit       = !sat && lenok_in &&
                  (seen_next >= pwf_pkg::POS_BITS'(pwf_pkg::WINDOW_LEN));
      cand_in.offset = seen_next - pwf_pkg::POS_BITS'(pwf_pkg::WINDOW_LEN);
      cand_in.bases  = win_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         win_ff   <= '0;
         lenok_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else if (accept) begin
         seen_ff  <= seen_in;
         win_ff   <= win_in;
         lenok_ff <= lenok_in;
         valid_ff <= hit;
      end else if (cand_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         cand_ff <= cand_in;
      end
   end

   assign cand_valid = valid_ff;
   assign cand       = cand_ff;

endmodule

// ===== design/pwf_check.sv =====
// Window tests (G/C count, Tm, start/end bases, base runs) and the result register.
// Depends on pwf_pkg.
module pwf_check (
   input  logic              clock,
   input  logic              reset,
   input  pwf_pkg::cfg_type  cfg,
   input  logic              cand_valid,
   output logic              cand_ready,
   input  pwf_pkg::cand_type cand,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwf_pkg::rsp_type  rsp
);

   localparam int WL = pwf_pkg::WINDOW_LEN;

   logic [1:0]                 b [WL];
   logic [WL-1:1]              eq;
   logic [WL:0]                hit;
   logic [pwf_pkg::GC_W-1:0]   gc;
   logic [pwf_pkg::TM_W-1:0]   tm;
   logic                       run_rej, start_rej, ends_rej, pass;
   logic                       valid_ff;
   pwf_pkg::rsp_type           rsp_ff, rsp_in;

   always_comb begin
      logic all_eq;
      gc = '0;
      for (int i = 0; i < WL; i++) begin
         b[i] = cand.bases[2*(WL-1-i) +: 2];
         gc   = gc + pwf_pkg::GC_W'(pwf_pkg::is_gc(b[i]));
      end
      for (int i = 1; i < WL; i++) begin
         eq[i] = (b[i] == b[i-1]);
      end
      hit    = '0;
      hit[0] = 1'b1;
      hit[1] = 1'b1;
      for (int k = 2; k <= WL; k++) begin
         for (int s = 0; s <= WL - k; s++) begin
            all_eq = 1'b1;
            for (int j = 1; j < k; j++) begin
               all_eq = all_eq & eq[s+j];
            end
            hit[k] = hit[k] | all_eq;
         end
      end
   end

   always_comb begin
      tm        = pwf_pkg::TM_W'(pwf_pkg::TM_BASE)
                + pwf_pkg::TM_W'(gc) * pwf_pkg::TM_W'(pwf_pkg::TM_STEP);
      run_rej   = (32'(cfg.run_limit) <= WL) ? hit[cfg.run_limit] : 1'b0;
      start_rej = cfg.rej_start && pwf_pkg::is_gc(b[0]) && pwf_pkg::is_gc(b[1])
                  && pwf_pkg::is_gc(b[2]);
      ends_rej  = cfg.rej_ends && (!pwf_pkg::is_gc(b[0]) || !pwf_pkg::is_gc(b[WL-1]));
      pass      = (gc >= cfg.min_gc) && (gc <= cfg.max_gc)
               && (tm >= cfg.min_tm) && (tm <= cfg.max_tm)
               && !run_rej && !start_rej && !ends_rej;
      rsp_in.tm     = tm[pwf_pkg::TM_OUT_W-1:0];
      rsp_in.gc     = gc;
      rsp_in.bases  = cand.bases;
      rsp_in.offset = cand.offset;
   end

   assign cand_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cand_valid && cand_ready) begin
         valid_ff <= pass;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cand_valid && cand_ready && pass) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   a_tm_formula: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.tm == pwf_pkg::TM_OUT_W'(pwf_pkg::TM_BASE
                              + pwf_pkg::TM_STEP * int'(rsp.gc)))
      else $error("result Tm does not match its G/C count");

   a_gc_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.gc >= cfg.min_gc) && (rsp.gc <= cfg.max_gc))
      else $error("result G/C count outside bounds");

   a_ends_gc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cfg.rej_ends |->
         pwf_pkg::is_gc(rsp.bases[pwf_pkg::WIN_W-1 -: 2]) && pwf_pkg::is_gc(rsp.bases[1:0]))
      else $error("result window ends in A or T");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== design/primer_window_filter_top.sv =====
// Top level of the primer window filter: control registers, window stage, check stage.
// Depends on pwf_pkg, pwf_window and pwf_check.
// A result is registered first in the window register and then in the result register after the
// transfer of the base that completes its window.
// Throughput: one base per cycle; the window register and the result register form a
// two-stage pipeline, stalled only by rsp_tready.
// Reset (synchronous, active high) clears the window, base count and length flag, empties
// both stages and restores the control registers to their default values.
module primer_window_filter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pwf_pkg::REQ_TDATA_W-1:0]   req_tdata,  // base[1:0], segment_length[17:2]
   input  logic                              req_tuser,  // segment_first
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pwf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // window_offset[15:0],
                                                         // window_bases[55:16],
                                                         // gc_count[60:56], tm_centi[73:61]
   input  logic                              csr_we,
   input  logic [pwf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pwf_pkg::cfg_type  cfg_ff;
   pwf_pkg::cand_type cand;
   pwf_pkg::rsp_type  rsp;
   logic              cand_valid, cand_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_gc    <= pwf_pkg::MIN_GC_RST;
         cfg_ff.max_gc    <= pwf_pkg::MAX_GC_RST;
         cfg_ff.min_tm    <= pwf_pkg::MIN_TM_RST;
         cfg_ff.max_tm    <= pwf_pkg::MAX_TM_RST;
         cfg_ff.run_limit <= pwf_pkg::RUN_LIMIT_RST;
         cfg_ff.rej_start <= 1'b1;
         cfg_ff.rej_ends  <= 1'b1;
      end else if (csr_we) begin
         unique case (pwf_pkg::csr_index_type'(csr_index))
            pwf_pkg::CSR_MIN_GC:    cfg_ff.min_gc    <= csr_wdata[pwf_pkg::GC_W-1:0];
            pwf_pkg::CSR_MAX_GC:    cfg_ff.max_gc    <= csr_wdata[pwf_pkg::GC_W-1:0];
            pwf_pkg::CSR_MIN_TM:    cfg_ff.min_tm    <= csr_wdata[pwf_pkg::TM_W-1:0];
            pwf_pkg::CSR_MAX_TM:    cfg_ff.max_tm    <= csr_wdata[pwf_pkg::TM_W-1:0];
            pwf_pkg::CSR_RUN_LIMIT: cfg_ff.run_limit <= csr_wdata[pwf_pkg::RUN_W-1:0];
            pwf_pkg::CSR_REJ_START: cfg_ff.rej_start <= csr_wdata[0];
            pwf_pkg::CSR_REJ_ENDS:  cfg_ff.rej_ends  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   pwf_window u_window (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .base           (req_tdata[1:0]),
      .segment_first  (req_tuser),
      .segment_length (req_tdata[pwf_pkg::LEN_W+1:2]),
      .cand_valid     (cand_valid),
      .cand_ready     (cand_ready),
      .cand           (cand)
   );

   pwf_check u_check (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cand_valid (cand_valid),
      .cand_ready (cand_ready),
      .cand       (cand),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {(pwf_pkg::RSP_TDATA_W - $bits(pwf_pkg::rsp_type))'(0), rsp};

endmodule

// ===== verif/pwf_window_checker.sv =====
`timescale 1ns / 1ps
// Base codes shared by the test files, and the checker that predicts and compares primer results.
// Depends on pwf_pkg; instantiated by primer_window_filter_top_test beside the filter.
package pwf_test_pkg;

   typedef enum logic [1:0] {
      BASE_A = 2'd0,
      BASE_C = 2'd1,
      BASE_G = 2'd2,
      BASE_T = 2'd3
   } base_type;

endpackage

module pwf_window_checker
   import pwf_pkg::*;
   import pwf_test_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // base[1:0], segment_length[17:2]
   input  logic                   req_tuser,  // segment_first
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // window_offset, window_bases, gc_count, tm_centi
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);

   localparam int TM_FLOOR  = 3128;
   localparam int TM_PER_GC = 205;
   localparam int REPORT_MAX = 10;

   cfg_type             settings;
   logic [WIN_W-1:0]    window_q;
   logic [POS_BITS-1:0] seen_count;
   logic                length_ok;
   rsp_type             primer_queue[$];

   function automatic logic is_strong(input logic [1:0] b);
      return b == BASE_C || b == BASE_G;
   endfunction

   function automatic logic [1:0] base_at(input int i);
      return window_q[2*(WINDOW_LEN-1-i) +: 2];
   endfunction

   function automatic logic screen_base(input logic [1:0] b, input logic first,
                                        input logic [LEN_W-1:0] len, output rsp_type found);
      int gc;
      int tm;
      int run;
      int longest;
      int i;
      gc = 0;
      run = 1;
      longest = 1;
      found = '0;
      if (first) begin
         seen_count = '0;
         window_q = '0;
         length_ok = len >= 2 * WINDOW_LEN;
      end
      if (seen_count == {POS_BITS{1'b1}})
         return 1'b0;
      seen_count = seen_count + POS_BITS'(1);
      window_q = {window_q[WIN_W-3:0], b};
      if (!length_ok || seen_count < WINDOW_LEN)
         return 1'b0;
      for (i = 0; i < WINDOW_LEN; i++) begin
         if (is_strong(base_at(i)))
            gc++;
         if (i > 0) begin
            run = (base_at(i) == base_at(i - 1)) ? run + 1 : 1;
            if (run > longest)
               longest = run;
         end
      end
      if (gc < settings.min_gc || gc > settings.max_gc)
         return 1'b0;
      tm = TM_FLOOR + TM_PER_GC * gc;
      if (tm < settings.min_tm || tm > settings.max_tm)
         return 1'b0;
      if (settings.rej_start && is_strong(base_at(0)) && is_strong(base_at(1)) &&
          is_strong(base_at(2)))
         return 1'b0;
      if (settings.rej_ends && (!is_strong(base_at(0)) || !is_strong(base_at(WINDOW_LEN - 1))))
         return 1'b0;
      if (longest >= settings.run_limit)
         return 1'b0;
      found.offset = seen_count - POS_BITS'(WINDOW_LEN);
      found.bases  = window_q;
      found.gc     = GC_W'(gc);
      found.tm     = TM_OUT_W'(tm);
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         settings = '{min_gc: MIN_GC_RST, max_gc: MAX_GC_RST, min_tm: MIN_TM_RST,
                      max_tm: MAX_TM_RST, run_limit: RUN_LIMIT_RST,
                      rej_start: 1'b1, rej_ends: 1'b1};
         window_q = '0;
         seen_count = '0;
         length_ok = 1'b0;
         primer_queue.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_GC:    settings.min_gc = csr_wdata[GC_W-1:0];
               CSR_MAX_GC:    settings.max_gc = csr_wdata[GC_W-1:0];
               CSR_MIN_TM:    settings.min_tm = csr_wdata[TM_W-1:0];
               CSR_MAX_TM:    settings.max_tm = csr_wdata[TM_W-1:0];
               CSR_RUN_LIMIT: settings.run_limit = csr_wdata[RUN_W-1:0];
               CSR_REJ_START: settings.rej_start = csr_wdata[0];
               CSR_REJ_ENDS:  settings.rej_ends = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (primer_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t unexpected primer: off=%0d bases=%h gc=%0d tm=%0d",
                           $realtime, got.offset, got.bases, got.gc, got.tm);
            end else begin
               want = primer_queue.pop_front();
               checked++;
               if (got.offset != want.offset || got.bases != want.bases ||
                   got.gc != want.gc || got.tm != want.tm) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("%0t primer mismatch: want off=%0d bases=%h gc=%0d tm=%0d, %s",
                              $realtime, want.offset, want.bases, want.gc, want.tm,
                              $sformatf("got off=%0d bases=%h gc=%0d tm=%0d",
                                        got.offset, got.bases, got.gc, got.tm));
               end
            end
         end
         if (req_tvalid && req_tready &&
             screen_base(req_tdata[1:0], req_tuser, req_tdata[LEN_W+1:2], want))
            primer_queue.push_back(want);
      end
      pending = primer_queue.size();
   end

endmodule

// ===== verif/primer_window_filter_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for primer_window_filter_top: a directed primer, then random segments
// under several filter settings and idle patterns.
// Depends on pwf_pkg, pwf_test_pkg and pwf_window_checker.
module primer_window_filter_top_test;
   import pwf_pkg::*;
   import pwf_test_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_BASES    = 128;
   localparam int SETTING_COUNT  = 9;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int checked;
   int req_idle_pct;
   int rsp_idle_pct;
   int cycle_count;
   int bases_sent;
   int settings_used;

   base_type directed_primer [WINDOW_LEN] = '{
      BASE_C, BASE_A, BASE_C, BASE_A, BASE_G, BASE_T, BASE_G, BASE_T, BASE_C, BASE_A,
      BASE_C, BASE_A, BASE_G, BASE_T, BASE_G, BASE_T, BASE_C, BASE_A, BASE_G, BASE_C};

   primer_window_filter_top dut (.*);

   pwf_window_checker window_check (.*);

   initial begin : clock_gen
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_base(input logic [1:0] b, input logic first, input logic [LEN_W-1:0] len);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= {{(REQ_TDATA_W-LEN_W-2){1'b0}}, len, b};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bases_sent++;
   endtask

   function automatic base_type next_base(input base_type prev, input int gc_pct);
      base_type b;
      int tries;
      b = prev;
      for (tries = 0; tries < 4; tries++) begin
         if ($urandom_range(99) < gc_pct)
            b = $urandom_range(1) ? BASE_C : BASE_G;
         else
            b = $urandom_range(1) ? BASE_A : BASE_T;
         if (b != prev)
            break;
      end
      return b;
   endfunction

   task automatic send_segment();
      int count;
      int stated;
      int mode;
      int gc_pct;
      int i;
      base_type b;
      mode = $urandom_range(9);
      gc_pct = $urandom_range(35, 75);
      count = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(21, 70);
      case ($urandom_range(9))
         0: stated = $urandom_range(0, 39);
         1: stated = 39;
         2: stated = 65535;
         3: stated = $urandom_range(65535);
         4: stated = 40;
         default: stated = (count < 40) ? 40 : count;
      endcase
      b = base_type'($urandom_range(3));
      for (i = 0; i < count; i++) begin
         if (mode == 0)
            b = base_type'($urandom_range(3));
         else if (mode > 1)
            b = next_base(b, gc_pct);
         send_base(b, i == 0, (i == 0) ? LEN_W'(stated) : LEN_W'($urandom));
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // pad narrow registers with random upper bits; the filter keeps only the field width
   task automatic apply_settings(input cfg_type s);
      put_reg(CSR_MIN_GC, {(CSR_DATA_W-GC_W)'($urandom), s.min_gc});
      put_reg(CSR_MAX_GC, {(CSR_DATA_W-GC_W)'($urandom), s.max_gc});
      put_reg(CSR_MIN_TM, s.min_tm);
      put_reg(CSR_MAX_TM, s.max_tm);
      put_reg(CSR_RUN_LIMIT, {(CSR_DATA_W-RUN_W)'($urandom), s.run_limit});
      put_reg(CSR_REJ_START, {(CSR_DATA_W-1)'($urandom), s.rej_start});
      put_reg(CSR_REJ_ENDS, {(CSR_DATA_W-1)'($urandom), s.rej_ends});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic cfg_type settings_for(input int k);
      cfg_type s;
      case (k)
         0: s = '{min_gc: 5'd9, max_gc: 5'd11, min_tm: 14'd5240, max_tm: 14'd5540,
                  run_limit: 5'd3, rej_start: 1'b1, rej_ends: 1'b1};
         1: s = '{min_gc: 5'd0, max_gc: 5'd20, min_tm: 14'd0, max_tm: 14'd10000,
                  run_limit: 5'd21, rej_start: 1'b0, rej_ends: 1'b0};
         3: s = '{min_gc: 5'd20, max_gc: 5'd0, min_tm: 14'd10000, max_tm: 14'd0,
                  run_limit: 5'd1, rej_start: 1'b1, rej_ends: 1'b1};
         4: s = '{min_gc: 5'd0, max_gc: 5'd31, min_tm: 14'd0, max_tm: 14'h3FFF,
                  run_limit: 5'd0, rej_start: 1'b0, rej_ends: 1'b1};
         6: s = '{min_gc: 5'd0, max_gc: 5'd20, min_tm: 14'd3128, max_tm: 14'd7228,
                  run_limit: 5'd2, rej_start: 1'b1, rej_ends: 1'b1};
         7: s = '{min_gc: 5'd0, max_gc: 5'd20, min_tm: 14'd5383, max_tm: 14'd5383,
                  run_limit: 5'd31, rej_start: 1'b1, rej_ends: 1'b0};
         default: begin
            s.min_gc = GC_W'($urandom_range(4, 12));
            s.max_gc = s.min_gc + GC_W'($urandom_range(6));
            s.min_tm = TM_W'($urandom_range(3000, 5600));
            s.max_tm = s.min_tm + TM_W'($urandom_range(200, 2500));
            s.run_limit = RUN_W'($urandom_range(2, 6));
            s.rej_start = 1'($urandom_range(1));
            s.rej_ends = 1'($urandom_range(1));
         end
      endcase
      return s;
   endfunction

   initial begin : stimulus
      int k;
      int i;
      int phase_start;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_idle_pct = 23;
      rsp_idle_pct = 81;
      cycle_count = 0;
      bases_sent = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no segment mark yet: nothing may pass
      send_base(BASE_T, 1'b0, 16'hFFFF);
      send_base(BASE_G, 1'b0, 16'h0000);
      for (i = 0; i < WINDOW_LEN; i++)
         send_base(directed_primer[i], i == 0, (i == 0) ? 16'hFFFF : 16'h0000);
      send_base(BASE_T, 1'b0, 16'hFFFF);

      for (k = 0; k < SETTING_COUNT; k++) begin
         case (k / 3)
            0: begin
               req_idle_pct = 23;
               rsp_idle_pct = 81;
            end
            1: begin
               req_idle_pct = 81;
               rsp_idle_pct = 23;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         settle();
         apply_settings(settings_for(k));
         phase_start = bases_sent;
         while (bases_sent - phase_start < PHASE_BASES)
            send_segment();
      end

      settle();

      $display("covered %0d bases under %0d filter settings with stalls on either side",
               bases_sent, settings_used);
      $display("%0d primer results compared, %0d mismatches, %0d still awaited",
               checked, fail_count, pending);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
design/pwf_pkg.sv
design/pwf_window.sv
design/pwf_check.sv
design/primer_window_filter_top.sv
verif/pwf_window_checker.sv
verif/primer_window_filter_top_test.sv
